[src/l2ra_pkg.sv]
// Package with types and constants for the L2 router ARP responder.
`timescale 1ns / 1ps
package l2ra_pkg;
  localparam int ROUTE_ENTRIES = 16;
  localparam int IDX_W = $clog2(ROUTE_ENTRIES);
  localparam int CNT_W = 5;

  localparam logic [15:0] ETH_IPV4 = 16'h0800;
  localparam logic [15:0] ETH_ARP = 16'h0806;
  localparam logic [47:0] ARP_FIXED_EXPECT = 48'h000108000604;
  localparam logic [15:0] ARP_REQUEST_CODE = 16'd1;
  localparam logic [15:0] ARP_REPLY_CODE = 16'd2;
  localparam logic [7:0] ARP_GATEWAY_OCTET = 8'd254;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_CLASSIFY = 1'b1;

  localparam logic [1:0] CFG_OWN_MAC = 2'd0;
  localparam logic [1:0] CFG_DROP_THRESHOLD = 2'd1;
  localparam logic [1:0] CFG_ROUTE_COUNT = 2'd2;

  localparam logic [1:0] ACT_DROP = 2'd0;
  localparam logic [1:0] ACT_FORWARD = 2'd1;
  localparam logic [1:0] ACT_ARP_REPLY = 2'd2;

  localparam logic [2:0] DR_NONE = 3'd0;
  localparam logic [2:0] DR_RANDOM = 3'd1;
  localparam logic [2:0] DR_MISS = 3'd2;
  localparam logic [2:0] DR_ETHERTYPE = 3'd3;
  localparam logic [2:0] DR_ARP = 3'd4;

  typedef struct packed {
    logic        operation;
    logic [3:0]  entry_index;
    logic [31:0] entry_ip;
    logic [47:0] entry_mac;
    logic [15:0] ethertype;
    logic [47:0] dest_mac;
    logic [47:0] arp_fixed;
    logic [15:0] arp_oper;
    logic [31:0] target_ip;
    logic [31:0] sender_ip;
    logic [47:0] sender_mac;
    logic [31:0] random_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [2:0]  drop_reason;
    logic [47:0] out_eth_src;
    logic [47:0] out_eth_dest;
    logic [47:0] out_arp_sender_mac;
    logic [47:0] out_arp_target_mac;
    logic [31:0] out_arp_sender_ip;
    logic [31:0] out_arp_target_ip;
    logic [15:0] out_arp_oper;
  } out_item_t;

  // Search token that travels down the cell row.
  typedef struct packed {
    logic        exact_hit;
    logic        net_hit;
    logic [47:0] hit_mac;
  } search_t;
endpackage

[src/l2_router_arp_responder.sv]
// Top level of the L2 router ARP responder.
`timescale 1ns / 1ps
// Usage: items arrive on the in channel (in_valid/in_stall/in_data). A load
// item writes one route entry and gives no result; a classify item gives one
// result on the out channel (out_valid/out_stall/out_data). Configuration is
// written through cfg_we/cfg_index/cfg_data while the block is idle.
// A classify item is compared against all route cells at once, the cell
// row passing a search token from index zero upward; the result is
// registered, so it appears in the cycle after its transfer.
// Throughput is one item per cycle while out_stall stays low; the output
// register holds one result, and while it is full and stalled the input
// channel stalls, so a result is never lost.
// Reset (rst, synchronous) clears the configuration registers, the route
// cells and the output valid flag; the block accepts items as soon as reset ends.
module l2_router_arp_responder (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [1:0]             cfg_index,
  input  logic [47:0]            cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  l2ra_pkg::in_item_t     in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output l2ra_pkg::out_item_t    out_data
);
  localparam int N = l2ra_pkg::ROUTE_ENTRIES;

  logic [47:0] own_mac;
  logic [31:0] drop_threshold;
  logic [l2ra_pkg::CNT_W-1:0] route_count;
  l2ra_pkg::search_t chain [N+1];
  l2ra_pkg::out_item_t res;
  logic in_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_mac <= '0;
      drop_threshold <= '0;
      route_count <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        l2ra_pkg::CFG_OWN_MAC: own_mac <= cfg_data;
        l2ra_pkg::CFG_DROP_THRESHOLD: drop_threshold <= cfg_data[31:0];
        l2ra_pkg::CFG_ROUTE_COUNT: route_count <= cfg_data[l2ra_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_stall = out_valid && out_stall;
  assign in_fire = in_valid && !in_stall;

  assign chain[0] = '{exact_hit: 1'b0, net_hit: 1'b0, hit_mac: 48'd0};

  for (genvar g = 0; g < N; g++) begin : g_cell
    l2ra_cell u_cell (
      .clk(clk),
      .rst(rst),
      .load_en(in_fire && in_data.operation == l2ra_pkg::OP_LOAD &&
               in_data.entry_index == l2ra_pkg::IDX_W'(g)),
      .load_ip(in_data.entry_ip),
      .load_mac(in_data.entry_mac),
      .active({1'b0, route_count} > (l2ra_pkg::CNT_W+1)'(g)),
      .key_ip(in_data.target_ip),
      .search_in(chain[g]),
      .search_out(chain[g+1])
    );
  end

  always_comb begin
    res = '0;
    if (in_data.ethertype == l2ra_pkg::ETH_IPV4) begin
      if (drop_threshold != '0 && in_data.random_value <= drop_threshold) begin
        res.drop_reason = l2ra_pkg::DR_RANDOM;
      end else if (in_data.dest_mac == own_mac && chain[N].exact_hit) begin
        res.action = l2ra_pkg::ACT_FORWARD;
        res.out_eth_src = own_mac;
        res.out_eth_dest = chain[N].hit_mac;
      end else begin
        res.drop_reason = l2ra_pkg::DR_MISS;
      end
    end else if (in_data.ethertype == l2ra_pkg::ETH_ARP) begin
      if (in_data.arp_oper == l2ra_pkg::ARP_REQUEST_CODE &&
          in_data.arp_fixed == l2ra_pkg::ARP_FIXED_EXPECT &&
          in_data.target_ip[7:0] == l2ra_pkg::ARP_GATEWAY_OCTET &&
          chain[N].net_hit) begin
        res.action = l2ra_pkg::ACT_ARP_REPLY;
        res.out_eth_src = own_mac;
        res.out_eth_dest = in_data.sender_mac;
        res.out_arp_sender_mac = own_mac;
        res.out_arp_target_mac = in_data.sender_mac;
        res.out_arp_sender_ip = in_data.target_ip;
        res.out_arp_target_ip = in_data.sender_ip;
        res.out_arp_oper = l2ra_pkg::ARP_REPLY_CODE;
      end else begin
        res.drop_reason = l2ra_pkg::DR_ARP;
      end
    end else begin
      res.drop_reason = l2ra_pkg::DR_ETHERTYPE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= (in_data.operation == l2ra_pkg::OP_CLASSIFY);
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_data.operation == l2ra_pkg::OP_CLASSIFY) begin
      out_data <= res;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result lost");
  a_no_accept: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> in_stall)
    else $error("input accepted while output full");
  a_fwd_src: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.action == l2ra_pkg::ACT_FORWARD |->
    out_data.drop_reason == l2ra_pkg::DR_NONE)
    else $error("forward with drop reason");
  a_load_quiet: assert property (@(posedge clk) disable iff (rst)
    in_fire && in_data.operation == l2ra_pkg::OP_LOAD |=> !out_valid)
    else $error("load produced a result");
endmodule

[src/l2ra_cell.sv]
// One route cell: holds an entry, compares it and passes the search token on.
`timescale 1ns / 1ps
module l2ra_cell (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             load_en,
  input  logic [31:0]                      load_ip,
  input  logic [47:0]                      load_mac,
  input  logic                             active,
  input  logic [31:0]                      key_ip,
  input  l2ra_pkg::search_t                search_in,
  output l2ra_pkg::search_t                search_out
);
  logic [31:0] ip;
  logic [47:0] mac;
  logic exact;
  logic net;

  always_ff @(posedge clk) begin
    if (rst) begin
      ip <= '0;
      mac <= '0;
    end else if (load_en) begin
      ip <= load_ip;
      mac <= load_mac;
    end
  end

  assign exact = active && (ip == key_ip);
  assign net = active && (ip[31:8] == key_ip[31:8]);

  // An earlier hit keeps its MAC: the lowest index wins.
  always_comb begin
    search_out.exact_hit = search_in.exact_hit || exact;
    search_out.net_hit = search_in.net_hit || net;
    search_out.hit_mac = search_in.exact_hit ? search_in.hit_mac :
                         (exact ? mac : search_in.hit_mac);
  end
endmodule

[sim/l2_router_arp_responder_tb.sv]
// Self-checking testbench for the L2 router ARP responder.
`timescale 1ns / 1ps
module l2_router_arp_responder_tb;
  localparam int LIMIT_CYCLES = 400000;
  localparam int N_RANDOM = 1630;
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = l2ra_pkg::CFG_OWN_MAC;
  logic [47:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  l2ra_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  l2ra_pkg::out_item_t out_data;

  l2_router_arp_responder uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Shadow copy of the router state.
  logic [47:0] my_mac;
  logic [31:0] threshold;
  logic [4:0] n_routes;
  logic [31:0] ip_tab [l2ra_pkg::ROUTE_ENTRIES];
  logic [47:0] mac_tab [l2ra_pkg::ROUTE_ENTRIES];

  l2ra_pkg::out_item_t verdicts_due [$];
  int cycles = 0;
  int mismatches = 0;
  int verdicts_seen = 0;
  int n_forward = 0;
  int n_arp = 0;
  int n_drop = 0;
  int send_idle = 0;
  int recv_idle = 0;

  // Computes the verdict for one header; returns 0 for a route load.
  function automatic bit classify(input l2ra_pkg::in_item_t it,
                                  output l2ra_pkg::out_item_t v);
    int lim;
    bit hit;
    v = '0;
    hit = 1'b0;
    lim = (n_routes > l2ra_pkg::ROUTE_ENTRIES) ? l2ra_pkg::ROUTE_ENTRIES : n_routes;
    if (it.operation == l2ra_pkg::OP_LOAD) begin
      ip_tab[it.entry_index] = it.entry_ip;
      mac_tab[it.entry_index] = it.entry_mac;
      return 1'b0;
    end
    if (it.ethertype == l2ra_pkg::ETH_IPV4) begin
      if (threshold != 0 && it.random_value <= threshold) begin
        v.drop_reason = l2ra_pkg::DR_RANDOM;
        return 1'b1;
      end
      if (it.dest_mac == my_mac) begin
        for (int i = 0; i < lim; i++) begin
          if (!hit && ip_tab[i] == it.target_ip) begin
            hit = 1'b1;
            v.action = l2ra_pkg::ACT_FORWARD;
            v.out_eth_src = my_mac;
            v.out_eth_dest = mac_tab[i];
          end
        end
      end
      if (!hit) v.drop_reason = l2ra_pkg::DR_MISS;
    end else if (it.ethertype == l2ra_pkg::ETH_ARP) begin
      if (it.arp_oper == l2ra_pkg::ARP_REQUEST_CODE &&
          it.arp_fixed == l2ra_pkg::ARP_FIXED_EXPECT &&
          it.target_ip[7:0] == l2ra_pkg::ARP_GATEWAY_OCTET) begin
        for (int i = 0; i < lim; i++) begin
          if (ip_tab[i][31:8] == it.target_ip[31:8]) hit = 1'b1;
        end
      end
      if (hit) begin
        v.action = l2ra_pkg::ACT_ARP_REPLY;
        v.out_eth_src = my_mac;
        v.out_eth_dest = it.sender_mac;
        v.out_arp_sender_mac = my_mac;
        v.out_arp_target_mac = it.sender_mac;
        v.out_arp_sender_ip = it.target_ip;
        v.out_arp_target_ip = it.sender_ip;
        v.out_arp_oper = l2ra_pkg::ARP_REPLY_CODE;
      end else begin
        v.drop_reason = l2ra_pkg::DR_ARP;
      end
    end else begin
      v.drop_reason = l2ra_pkg::DR_ETHERTYPE;
    end
    return 1'b1;
  endfunction

  // Output side: random stall and comparison against the oldest verdict.
  always @(posedge clk) begin
    l2ra_pkg::out_item_t want;
    cycles <= cycles + 1;
    if (!rst && out_valid && !out_stall) begin
      verdicts_seen <= verdicts_seen + 1;
      if (verdicts_due.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected verdict %h", out_data);
      end else begin
        want = verdicts_due.pop_front();
        if (want !== out_data) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) begin
            $display("mismatch act %0d/%0d reason %0d/%0d", want.action,
                     out_data.action, want.drop_reason, out_data.drop_reason);
            $display("  expected %h", want);
            $display("  actual   %h", out_data);
          end
        end
        unique case (want.action)
          l2ra_pkg::ACT_FORWARD: n_forward <= n_forward + 1;
          l2ra_pkg::ACT_ARP_REPLY: n_arp <= n_arp + 1;
          default: n_drop <= n_drop + 1;
        endcase
      end
    end
    out_stall <= ($urandom_range(99) < recv_idle);
  end

  always @(posedge clk) begin
    if (cycles >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("** l2_router_arp_responder: FAILED **");
      $finish;
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [47:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    unique case (idx)
      l2ra_pkg::CFG_OWN_MAC: my_mac = val;
      l2ra_pkg::CFG_DROP_THRESHOLD: threshold = val[31:0];
      l2ra_pkg::CFG_ROUTE_COUNT: n_routes = val[4:0];
      default: ;
    endcase
  endtask

  // Presents one item, holding it until the transfer. Valid stays high after
  // the transfer only until the next send or drain replaces it.
  task automatic send(input l2ra_pkg::in_item_t it);
    l2ra_pkg::out_item_t v;
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (classify(it, v)) verdicts_due.push_back(v);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic l2ra_pkg::in_item_t rand_item();
    l2ra_pkg::in_item_t it;
    logic [383:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom, $urandom, $urandom, $urandom, $urandom};
    it = raw[$bits(l2ra_pkg::in_item_t)-1:0];
    return it;
  endfunction

  // Mostly well-formed IPv4 and ARP headers aimed at the loaded routes.
  function automatic l2ra_pkg::in_item_t shaped_item();
    l2ra_pkg::in_item_t it;
    int r;
    int e;
    it = rand_item();
    r = $urandom_range(99);
    e = $urandom_range(l2ra_pkg::ROUTE_ENTRIES - 1);
    it.operation = l2ra_pkg::OP_CLASSIFY;
    if (r < 12) begin
      it.operation = l2ra_pkg::OP_LOAD;
      if ($urandom_range(3) == 0) it.entry_ip = {ip_tab[0][31:8], it.entry_ip[7:0]};
    end else if (r < 55) begin
      it.ethertype = l2ra_pkg::ETH_IPV4;
      if ($urandom_range(4) != 0) it.dest_mac = my_mac;
      if ($urandom_range(3) != 0) it.target_ip = ip_tab[e];
    end else if (r < 92) begin
      it.ethertype = l2ra_pkg::ETH_ARP;
      if ($urandom_range(7) != 0) it.arp_fixed = l2ra_pkg::ARP_FIXED_EXPECT;
      if ($urandom_range(7) != 0) it.arp_oper = l2ra_pkg::ARP_REQUEST_CODE;
      if ($urandom_range(3) != 0) begin
        it.target_ip = {ip_tab[e][31:8], l2ra_pkg::ARP_GATEWAY_OCTET};
      end
    end
    return it;
  endfunction

  typedef struct {
    l2ra_pkg::in_item_t it;
    bit known;
    l2ra_pkg::out_item_t v;
  } row_t;

  row_t rows [$];

  function automatic row_t mk(input logic op, input logic [3:0] idx, input logic [31:0] eip,
                              input logic [47:0] emac, input logic [15:0] et,
                              input logic [47:0] dmac, input logic [47:0] afix,
                              input logic [15:0] aop, input logic [31:0] tip,
                              input logic [31:0] sip, input logic [47:0] smac,
                              input logic [31:0] rnd);
    row_t r;
    r.it = '{op, idx, eip, emac, et, dmac, afix, aop, tip, sip, smac, rnd};
    r.known = 1'b0;
    r.v = '0;
    return r;
  endfunction

  function automatic row_t known_drop(input row_t r, input logic [2:0] why);
    r.known = 1'b1;
    r.v = '0;
    r.v.drop_reason = why;
    return r;
  endfunction

  initial begin
    logic [47:0] mac_a;
    for (int i = 0; i < l2ra_pkg::ROUTE_ENTRIES; i++) begin
      ip_tab[i] = '0;
      mac_tab[i] = '0;
    end
    my_mac = '0;
    threshold = '0;
    n_routes = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, fresh after reset: no routes, so misses are plain.
    rows.push_back(known_drop(mk(l2ra_pkg::OP_CLASSIFY, 0, 0, 0, l2ra_pkg::ETH_IPV4,
                                 0, 0, 0, 0, 0, 0, 0), l2ra_pkg::DR_MISS));
    rows.push_back(known_drop(mk(l2ra_pkg::OP_CLASSIFY, 0, 0, 0, 16'hffff,
                                 '1, '1, '1, '1, '1, '1, '1), l2ra_pkg::DR_ETHERTYPE));
    rows.push_back(known_drop(mk(l2ra_pkg::OP_CLASSIFY, 0, 0, 0, l2ra_pkg::ETH_ARP, 0,
                                 l2ra_pkg::ARP_FIXED_EXPECT, l2ra_pkg::ARP_REQUEST_CODE,
                                 32'h0a0000fe, 1, 2, 0), l2ra_pkg::DR_ARP));
    foreach (rows[i]) begin
      send(rows[i].it);
      if (rows[i].known) verdicts_due[verdicts_due.size() - 1] = rows[i].v;
    end
    drain();
    rows.delete();

    mac_a = 48'h02aabbccddee;
    write_reg(l2ra_pkg::CFG_OWN_MAC, mac_a);
    write_reg(l2ra_pkg::CFG_ROUTE_COUNT, 48'd3);
    write_reg(l2ra_pkg::CFG_DROP_THRESHOLD, 48'd0);
    write_reg(CFG_UNUSED, 48'hffff);
    rows.push_back(mk(l2ra_pkg::OP_LOAD, 0, 32'h0a000001, 48'h111111111111,
                      0, 0, 0, 0, 0, 0, 0, 0));
    rows.push_back(mk(l2ra_pkg::OP_LOAD, 1, 32'h0a000001, 48'h222222222222,
                      0, 0, 0, 0, 0, 0, 0, 0));
    rows.push_back(mk(l2ra_pkg::OP_LOAD, 2, '1, '1, 0, 0, 0, 0, 0, 0, 0, 0));
    rows.push_back(mk(l2ra_pkg::OP_LOAD, 15, 32'hc0a80105, 48'h333333333333,
                      0, 0, 0, 0, 0, 0, 0, 0));
    rows.push_back(mk(l2ra_pkg::OP_CLASSIFY, 0, 0, 0, l2ra_pkg::ETH_IPV4, mac_a, 0, 0,
                      32'h0a000001, 0, 0, '1));
    rows.push_back(mk(l2ra_pkg::OP_CLASSIFY, 0, 0, 0, l2ra_pkg::ETH_IPV4, mac_a, 0, 0,
                      '1, 0, 0, 0));
    rows.push_back(known_drop(mk(l2ra_pkg::OP_CLASSIFY, 0, 0, 0, l2ra_pkg::ETH_IPV4,
                                 mac_a ^ 1, 0, 0, 32'h0a000001, 0, 0, 0),
                              l2ra_pkg::DR_MISS));
    rows.push_back(known_drop(mk(l2ra_pkg::OP_CLASSIFY, 0, 0, 0, l2ra_pkg::ETH_IPV4,
                                 mac_a, 0, 0, 32'hc0a80105, 0, 0, 0),
                              l2ra_pkg::DR_MISS));
    rows.push_back(mk(l2ra_pkg::OP_CLASSIFY, 0, 0, 0, l2ra_pkg::ETH_ARP, 0,
                      l2ra_pkg::ARP_FIXED_EXPECT, l2ra_pkg::ARP_REQUEST_CODE,
                      32'h0a0000fe, 32'h0a000009, 48'h0000deadbeef, 0));
    rows.push_back(mk(l2ra_pkg::OP_CLASSIFY, 0, 0, 0, l2ra_pkg::ETH_ARP, '1,
                      l2ra_pkg::ARP_FIXED_EXPECT, l2ra_pkg::ARP_REQUEST_CODE,
                      32'hfffffffe, '1, '1, 0));
    rows.push_back(known_drop(mk(l2ra_pkg::OP_CLASSIFY, 0, 0, 0, l2ra_pkg::ETH_ARP, 0,
                                 l2ra_pkg::ARP_FIXED_EXPECT, l2ra_pkg::ARP_REPLY_CODE,
                                 32'h0a0000fe, 0, 0, 0), l2ra_pkg::DR_ARP));
    rows.push_back(known_drop(mk(l2ra_pkg::OP_CLASSIFY, 0, 0, 0, l2ra_pkg::ETH_ARP, 0,
                                 l2ra_pkg::ARP_FIXED_EXPECT ^ 1, l2ra_pkg::ARP_REQUEST_CODE,
                                 32'h0a0000fe, 0, 0, 0), l2ra_pkg::DR_ARP));
    rows.push_back(known_drop(mk(l2ra_pkg::OP_CLASSIFY, 0, 0, 0, l2ra_pkg::ETH_ARP, 0,
                                 l2ra_pkg::ARP_FIXED_EXPECT, l2ra_pkg::ARP_REQUEST_CODE,
                                 32'h0a0000fd, 0, 0, 0), l2ra_pkg::DR_ARP));
    rows.push_back(known_drop(mk(l2ra_pkg::OP_CLASSIFY, 0, 0, 0, l2ra_pkg::ETH_ARP, 0,
                                 l2ra_pkg::ARP_FIXED_EXPECT, l2ra_pkg::ARP_REQUEST_CODE,
                                 32'hc0a801fe, 0, 0, 0), l2ra_pkg::DR_ARP));
    foreach (rows[i]) begin
      send(rows[i].it);
      if (rows[i].known) verdicts_due[verdicts_due.size() - 1] = rows[i].v;
    end
    drain();
    rows.delete();

    // Route count past the table size, and the extreme thresholds.
    write_reg(l2ra_pkg::CFG_ROUTE_COUNT, 48'd31);
    write_reg(l2ra_pkg::CFG_DROP_THRESHOLD, 48'hffffffff);
    send(mk(l2ra_pkg::OP_CLASSIFY, 0, 0, 0, l2ra_pkg::ETH_IPV4, mac_a, 0, 0,
            32'hc0a80105, 0, 0, '1).it);
    verdicts_due[verdicts_due.size() - 1] = '{drop_reason: l2ra_pkg::DR_RANDOM, default: '0};
    drain();
    write_reg(l2ra_pkg::CFG_DROP_THRESHOLD, 48'd1);
    send(mk(l2ra_pkg::OP_CLASSIFY, 0, 0, 0, l2ra_pkg::ETH_IPV4, mac_a, 0, 0,
            32'hc0a80105, 0, 0, 1).it);
    send(mk(l2ra_pkg::OP_CLASSIFY, 0, 0, 0, l2ra_pkg::ETH_IPV4, mac_a, 0, 0,
            32'hc0a80105, 0, 0, 2).it);
    send(mk(l2ra_pkg::OP_CLASSIFY, 0, 0, 0, l2ra_pkg::ETH_IPV4, mac_a, 0, 0,
            32'hc0a80105, 0, 0, 0).it);
    drain();

    // Random part in phases with different settings and idling.
    for (int ph = 0; ph < 6; ph++) begin
      send_idle = (ph < 2) ? 24 : (ph < 4) ? 56 : 0;
      recv_idle = (ph < 2) ? 56 : (ph < 4) ? 24 : 0;
      write_reg(l2ra_pkg::CFG_OWN_MAC,
                (ph == 5) ? '1 : (ph == 4) ? 48'd0 : 48'({$urandom, $urandom}));
      unique case (ph % 3)
        0: write_reg(l2ra_pkg::CFG_DROP_THRESHOLD, 48'd0);
        1: write_reg(l2ra_pkg::CFG_DROP_THRESHOLD, {16'd0, $urandom_range(32'h3fffffff)});
        default: write_reg(l2ra_pkg::CFG_DROP_THRESHOLD, 48'hffffffff);
      endcase
      write_reg(l2ra_pkg::CFG_ROUTE_COUNT, (ph == 0) ? 48'd16 : (ph == 3) ? 48'd0
                                           : 48'($urandom_range(31)));
      for (int i = 0; i < N_RANDOM / 6; i++) begin
        send(($urandom_range(9) == 0) ? rand_item() : shaped_item());
      end
      drain();
    end

    repeat (10) @(posedge clk);
    $display("Covered %0d verdicts: %0d forwarded, %0d ARP replies, %0d dropped.",
             verdicts_seen, n_forward, n_arp, n_drop);
    $display("Route loads, random drops and six register settings under stalls.");
    if (mismatches == 0 && verdicts_due.size() == 0) begin
      $display("** l2_router_arp_responder: PASSED **");
    end else begin
      $display("%0d mismatches, %0d verdicts missing", mismatches, verdicts_due.size());
      $display("** l2_router_arp_responder: FAILED **");
    end
    $finish;
  end
endmodule
